FILE: design/assert_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FCD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fcd_pkg.sv
// Types, constants and codes of the frame checksum deframer.
package fcd_pkg;

  localparam int MAX_PACKET = 255;
  localparam int MIN_PACKET = 5;
  localparam int BODY_START = 3;
  localparam int POS_W      = $clog2(MAX_PACKET + 2);

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL = CFG_IDX_W'(1);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_SHORT = 3'd1,
    STAT_BAD_FRAME = 3'd2,
    STAT_BAD_SUM   = 3'd3,
    STAT_TOO_LONG  = 3'd4
  } status_t;

  // One classified input byte, as queued between front and back.
  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       has_verdict;
    status_t    status;
    logic [7:0] command;
    logic [7:0] declared_length;
  } fcd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fcd_qstat_t;

endpackage

FILE: design/fcd_if.sv
// Channel interfaces: raw packet bytes in, result items out.
interface byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface result_if import fcd_pkg::*;;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  status_t    status;
  logic [7:0] command;
  logic [7:0] declared_length;
  logic       last_of_run;

  modport source (output valid, output kind, output payload_byte, output status,
                  output command, output declared_length, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input status,
                input command, input declared_length, input last_of_run,
                output ready);
endinterface

FILE: design/fcd_front.sv
// Front end: config registers, packet tracking and per-byte classification.
module fcd_front import fcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  byte_if.sink                  byte_ch,
  input  fcd_qstat_t            qstat,
  output logic                  push,
  output fcd_entry_t            push_entry
);

  `include "assert_macros.svh"

  logic [7:0]       head_byte;
  logic [7:0]       tail_byte;
  logic [POS_W-1:0] position;
  logic [7:0]       running_sum;
  logic [7:0]       prev_byte;
  logic [7:0]       prev2_byte;
  logic             head_matched;
  logic [7:0]       command_seen;
  logic [7:0]       length_seen;

  logic             accept;
  logic [POS_W-1:0] position_next;
  logic [7:0]       sum_next;
  logic             head_next;
  logic [7:0]       command_next;
  logic [7:0]       length_next;
  logic             emit;
  status_t          status;

  assign byte_ch.ready = !qstat.full;
  assign accept        = byte_ch.valid && byte_ch.ready;

  always_comb begin
    head_next    = (position == POS_W'(0)) ? (byte_ch.in_byte == head_byte) : head_matched;
    command_next = (position == POS_W'(1)) ? byte_ch.in_byte : command_seen;
    length_next  = (position == POS_W'(2)) ? byte_ch.in_byte : length_seen;

    // Byte two back cannot be the checksum byte, so it joins the sum.
    if (position >= POS_W'(BODY_START + 2) && position <= POS_W'(MAX_PACKET)) begin
      sum_next = running_sum + prev2_byte;
    end else begin
      sum_next = running_sum;
    end

    emit = (position >= POS_W'(BODY_START)) && (position < POS_W'(MAX_PACKET)) &&
           ({1'b0, position} < ((POS_W + 1)'(BODY_START) + (POS_W + 1)'(length_next)));

    position_next = (position <= POS_W'(MAX_PACKET)) ? position + POS_W'(1) : position;

    if (position_next > POS_W'(MAX_PACKET)) begin
      status = STAT_TOO_LONG;
    end else if (position_next < POS_W'(MIN_PACKET)) begin
      status = STAT_TOO_SHORT;
    end else if (!head_next || byte_ch.in_byte != tail_byte) begin
      status = STAT_BAD_FRAME;
    end else if (prev_byte != sum_next) begin
      status = STAT_BAD_SUM;
    end else begin
      status = STAT_OK;
    end

    push                       = accept && (emit || byte_ch.in_last);
    push_entry.has_payload     = emit;
    push_entry.payload_byte    = byte_ch.in_byte;
    push_entry.has_verdict     = byte_ch.in_last;
    push_entry.status          = status;
    push_entry.command         = command_next;
    push_entry.declared_length = length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= '0;
      tail_byte <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD: head_byte <= cfg_data[7:0];
        REG_TAIL: tail_byte <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && byte_ch.in_last)) begin
      position     <= '0;
      running_sum  <= '0;
      prev_byte    <= '0;
      prev2_byte   <= '0;
      head_matched <= 1'b0;
      command_seen <= '0;
      length_seen  <= '0;
    end else if (accept) begin
      position     <= position_next;
      running_sum  <= sum_next;
      prev_byte    <= byte_ch.in_byte;
      prev2_byte   <= prev_byte;
      head_matched <= head_next;
      command_seen <= command_next;
      length_seen  <= length_next;
    end
  end

  `FCD_ASSERT_IMPL(a_pos_saturates, clk, rst, 1'b1, position <= POS_W'(MAX_PACKET + 1),
                   "position ran past saturation")
  `FCD_ASSERT_NEXT(a_pos_clears, clk, rst, accept && byte_ch.in_last, position == '0,
                   "position not cleared after final byte")

endmodule

FILE: design/fcd_queue.sv
// Short queue of classified entries between front and back.
module fcd_queue import fcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  fcd_entry_t push_entry,
  input  logic       pop,
  output fcd_entry_t head,
  output fcd_qstat_t qstat
);

  `include "assert_macros.svh"

  fcd_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `FCD_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, !qstat.empty, "pop from empty queue")

endmodule

FILE: design/fcd_back.sv
// Back end: expand queued entries into result items behind an output register.
module fcd_back import fcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  fcd_entry_t head,
  input  fcd_qstat_t qstat,
  output logic       pop,
  result_if.source   result_ch
);

  `include "assert_macros.svh"

  logic       out_valid;
  logic       load;
  logic       phase;
  logic       phase_next;
  logic       item_kind;
  logic [7:0] item_payload;
  status_t    item_status;
  logic [7:0] item_command;
  logic [7:0] item_length;
  logic       item_last;

  logic       kind_q;
  logic [7:0] payload_q;
  status_t    status_q;
  logic [7:0] command_q;
  logic [7:0] length_q;
  logic       last_q;

  assign load = !out_valid || result_ch.ready;

  always_comb begin
    if (!phase && head.has_payload) begin
      item_kind    = KIND_PAYLOAD;
      item_payload = head.payload_byte;
      item_status  = STAT_OK;
      item_command = '0;
      item_length  = '0;
      item_last    = !head.has_verdict;
      phase_next   = head.has_verdict;
    end else begin
      item_kind    = KIND_VERDICT;
      item_payload = '0;
      item_status  = head.status;
      item_command = head.command;
      item_length  = head.declared_length;
      item_last    = 1'b1;
      phase_next   = 1'b0;
    end
    // Hold the entry while its verdict is still to come.
    pop = load && !qstat.empty && !phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= !qstat.empty;
      if (!qstat.empty) begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !qstat.empty) begin
      kind_q    <= item_kind;
      payload_q <= item_payload;
      status_q  <= item_status;
      command_q <= item_command;
      length_q  <= item_length;
      last_q    <= item_last;
    end
  end

  assign result_ch.valid           = out_valid;
  assign result_ch.kind            = kind_q;
  assign result_ch.payload_byte    = payload_q;
  assign result_ch.status          = status_q;
  assign result_ch.command         = command_q;
  assign result_ch.declared_length = length_q;
  assign result_ch.last_of_run     = last_q;

  `FCD_ASSERT_IMPL(a_phase_has_verdict, clk, rst, phase, !qstat.empty && head.has_verdict,
                   "verdict phase without a verdict entry")

endmodule

FILE: design/frame_checksum_deframer.sv
// Top level of the frame checksum deframer.
//
//   channel     dir  payload                                     transaction
//   byte_ch     in   in_byte, in_last                            valid && ready
//   result_ch   out  kind, payload_byte, status, command,        valid && ready
//                    declared_length, last_of_run
//   cfg         in   cfg_index, cfg_data                         cfg_we high
//
// One byte is accepted per cycle while the four-entry queue has room; the
// front classifies it combinationally, so a byte that carries payload or ends
// the packet enters the queue at the edge that accepts it, and from the queue
// head its result items are loaded into the output register. A byte that ends
// a payload run and carries the verdict holds the queue head until both of
// its result items are loaded, one output register load per result item.
// Reset is synchronous and clears config registers, packet state, the queue
// and the output valid. A stall on result_ch fills the queue, then drops
// byte_ch.ready; the output register holds its item until taken.
module frame_checksum_deframer import fcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  byte_if.sink                  byte_ch,
  result_if.source              result_ch
);

  logic       push;
  fcd_entry_t push_entry;
  logic       pop;
  fcd_entry_t head;
  fcd_qstat_t qstat;

  // Track packet position, checksum and framing; classify each byte.
  fcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_ch    (byte_ch),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple classification from delivery so each side can stall alone.
  fcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // Turn each entry into one or two result items.
  fcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .result_ch (result_ch)
  );

endmodule
